// File: rtl/cce_pkg.sv
// ============================================================================
// cce_pkg
// Shared types, constants and helpers for the control character escaper.
// ============================================================================
package cce_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHR_BSLASH = 8'h5c;
    localparam logic [7:0] CHR_U      = 8'h75;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_B      = 8'h62;
    localparam logic [7:0] CHR_F      = 8'h66;
    localparam logic [7:0] CHR_N      = 8'h6e;
    localparam logic [7:0] CHR_R      = 8'h72;
    localparam logic [7:0] CHR_T      = 8'h74;
    localparam logic [7:0] LEAD_C2    = 8'hc2;
    localparam logic [7:0] CHR_DEL    = 8'h7f;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_PAIR = 2'd2,
        KIND_UNI  = 2'd3
    } kind_t;

    // One queued job: optional held 0xc2 first, then the escape of val.
    typedef struct packed {
        logic       pre;
        kind_t      kind;
        logic [7:0] val;
        logic       fin;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_head_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
            r = 8'h30 + {4'h0, nib};
        else
            r = 8'h57 + {4'h0, nib};
        return r;
    endfunction

endpackage

// File: rtl/control_char_escaper_core.sv
// ============================================================================
// control_char_escaper_core
// Escapes control characters of a byte stream into backslash sequences.
//
//   channel  | handshake        | beat
//   ---------+------------------+-----------------------------------
//   input    | push / full      | in_byte, string_end
//   result   | pop / empty      | out_byte, run_last, string_done
//
// Input beats are taken one per cycle while the job queue has room.
// The back sequencer emits one output byte per unstalled cycle: 1 for plain
// bytes, 2 for letter escapes, 6 for \u00xx, plus 1 for a released 0xc2.
// A held 0xc2 mid-string produces no job. Reset clears the held lead,
// the queue and the output register. Either side may stall independently.
// ============================================================================
module control_char_escaper_core #(
    parameter int QUEUE_DEPTH = cce_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done
);

    logic               accept;
    logic               job_push;
    logic               job_pop;
    cce_pkg::job_t      job;
    cce_pkg::job_head_t head;

    assign accept = push && !full;

    cce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .string_end (string_end),
        .job_push   (job_push),
        .job        (job)
    );

    cce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job),
        .full   (full),
        .rd_en  (job_pop),
        .head   (head)
    );

    cce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .job_pop     (job_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

// File: rtl/cce_front.sv
// ============================================================================
// cce_front
// Accepts input beats, tracks a held 0xc2 lead byte and classifies each beat
// into an escape job.
// ============================================================================
module cce_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          string_end,
    output logic          job_push,
    output cce_pkg::job_t job
);

    logic lead_reg;
    logic lead_next;

    always_comb
    begin
        job.pre   = 1'b0;
        job.kind  = cce_pkg::KIND_NONE;
        job.val   = in_byte;
        job.fin   = string_end;
        lead_next = 1'b0;
        if (lead_reg && (in_byte inside {[8'h80:8'h9f]}))
        begin
            job.kind = cce_pkg::KIND_UNI;
        end
        else
        begin
            job.pre = lead_reg;
            if (in_byte < 8'h20)
            begin
                job.kind = cce_pkg::KIND_PAIR;
                case (in_byte)
                    8'h08:   job.val = cce_pkg::CHR_B;
                    8'h0c:   job.val = cce_pkg::CHR_F;
                    8'h0a:   job.val = cce_pkg::CHR_N;
                    8'h0d:   job.val = cce_pkg::CHR_R;
                    8'h09:   job.val = cce_pkg::CHR_T;
                    default: job.kind = cce_pkg::KIND_UNI;
                endcase
            end
            else if (in_byte == cce_pkg::CHR_DEL)
            begin
                job.kind = cce_pkg::KIND_UNI;
            end
            else if (in_byte == cce_pkg::LEAD_C2 && !string_end)
            begin
                lead_next = 1'b1;
            end
            else
            begin
                job.kind = cce_pkg::KIND_BYTE;
            end
        end
        if (string_end)
            lead_next = 1'b0;
    end

    assign job_push = accept && (job.pre || job.kind != cce_pkg::KIND_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lead_reg <= 1'b0;
        else if (accept)
            lead_reg <= lead_next;
    end

endmodule

// File: rtl/cce_queue.sv
// ============================================================================
// cce_queue
// Small register queue of escape jobs between front and back.
// ============================================================================
module cce_queue #(
    parameter int DEPTH = cce_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  cce_pkg::job_t      wr_job,
    output logic               full,
    input  logic               rd_en,
    output cce_pkg::job_head_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cce_pkg::job_t   mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;

    assign full       = (cnt_reg == FULL_CNT);
    assign head.valid = (cnt_reg != '0);
    assign head.job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + CW'(1);
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
    end

endmodule

// File: rtl/cce_back.sv
// ============================================================================
// cce_back
// Walks the head job into a registered output beat, a byte per unstalled cycle.
// ============================================================================
module cce_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cce_pkg::job_head_t head,
    output logic               job_pop,
    input  logic               pop,
    output logic               empty,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               string_done
);

    logic [2:0] pos_reg;
    logic [2:0] base_len;
    logic [2:0] len;
    logic [2:0] idx;
    logic [7:0] sel_byte;
    logic       at_last;
    logic       load;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       done_reg;

    always_comb
    begin
        case (head.job.kind)
            cce_pkg::KIND_BYTE: base_len = 3'd1;
            cce_pkg::KIND_PAIR: base_len = 3'd2;
            cce_pkg::KIND_UNI:  base_len = 3'd6;
            default:            base_len = 3'd0;
        endcase
        len     = base_len + {2'b00, head.job.pre};
        idx     = pos_reg - {2'b00, head.job.pre};
        at_last = (pos_reg == len - 3'd1);
    end

    always_comb
    begin
        sel_byte = head.job.val;
        if (head.job.pre && pos_reg == 3'd0)
        begin
            sel_byte = cce_pkg::LEAD_C2;
        end
        else
        begin
            case (head.job.kind)
                cce_pkg::KIND_PAIR:
                    sel_byte = (idx == 3'd0) ? cce_pkg::CHR_BSLASH : head.job.val;
                cce_pkg::KIND_UNI:
                begin
                    case (idx)
                        3'd0:    sel_byte = cce_pkg::CHR_BSLASH;
                        3'd1:    sel_byte = cce_pkg::CHR_U;
                        3'd2:    sel_byte = cce_pkg::CHR_ZERO;
                        3'd3:    sel_byte = cce_pkg::CHR_ZERO;
                        3'd4:    sel_byte = cce_pkg::hex_digit(head.job.val[7:4]);
                        default: sel_byte = cce_pkg::hex_digit(head.job.val[3:0]);
                    endcase
                end
                default: sel_byte = head.job.val;
            endcase
        end
    end

    assign load    = head.valid && (!valid_reg || pop);
    assign job_pop = load && at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                pos_reg <= at_last ? 3'd0 : pos_reg + 3'd1;
            if (load)
                valid_reg <= 1'b1;
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            last_reg <= at_last;
            done_reg <= at_last && head.job.fin;
        end
    end

    assign empty       = !valid_reg;
    assign out_byte    = byte_reg;
    assign run_last    = last_reg;
    assign string_done = done_reg;

endmodule
